FILE: design/wavh_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package wavh_pkg;

    localparam logic [31:0] SIG_RIFF    = 32'h4646_4952;
    localparam logic [31:0] SIG_WAVE    = 32'h4556_4157;
    localparam logic [31:0] SIG_FMT     = 32'h2074_6d66;
    localparam logic [31:0] SIG_DATA    = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM     = 16'd1;

    typedef enum logic [3:0] {
        PH_RIFF      = 4'd0,
        PH_RLEN      = 4'd1,
        PH_WAVE      = 4'd2,
        PH_CID       = 4'd3,
        PH_CLEN      = 4'd4,
        PH_FMT_CODE  = 4'd5,
        PH_FMT_CH    = 4'd6,
        PH_FMT_RATE  = 4'd7,
        PH_FMT_BRATE = 4'd8,
        PH_FMT_ALIGN = 4'd9,
        PH_FMT_BITS  = 4'd10,
        PH_SKIP      = 4'd11,
        PH_DATA      = 4'd12,
        PH_BAD       = 4'd13,
        PH_NOCODEC   = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        ST_HEADER      = 2'd0,
        ST_PAYLOAD     = 2'd1,
        ST_INVALID     = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  idx;
        logic [31:0] tag;
        logic [31:0] clen;
        logic [31:0] skip;
        logic [15:0] fmt;
        logic [31:0] rate;
        logic [15:0] chan;
        logic [15:0] bits;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase: PH_RIFF, idx: 2'd0, tag: 32'd0, clen: 32'd0, skip: 32'd0,
        fmt: 16'd0, rate: 32'd0, chan: 16'd0, bits: 16'd0
    };

endpackage

FILE: design/wavh_step.sv
// Next-state and result logic for one stream word of the header parser.
module wavh_step (
    input  wavh_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_eos,
    output wavh_pkg::t_parse_state o_state,
    output wavh_pkg::t_status      o_status,
    output logic [7:0]             o_payload
);
    import wavh_pkg::*;

    logic [31:0] w_tag_sh;
    logic [31:0] w_clen_sh;
    logic [31:0] w_skip_dec;
    logic [2:0]  w_idx_inc;
    logic        w_done4;
    logic        w_done2;
    logic [1:0]  w_idx4;
    logic [1:0]  w_idx2;
    t_parse_state n_st;
    t_status      w_status;
    logic [7:0]   w_pay;

    assign w_tag_sh   = {i_byte, i_state.tag[31:8]};
    assign w_clen_sh  = {i_byte, i_state.clen[31:8]};
    assign w_skip_dec = (i_state.skip != 32'd0) ? i_state.skip - 32'd1 : 32'd0;
    assign w_idx_inc  = {1'b0, i_state.idx} + 3'd1;
    assign w_done4    = (w_idx_inc >= 3'd4);
    assign w_done2    = (w_idx_inc >= 3'd2);
    assign w_idx4     = w_done4 ? 2'd0 : w_idx_inc[1:0];
    assign w_idx2     = w_done2 ? 2'd0 : w_idx_inc[1:0];

    always_comb begin
        n_st     = i_state;
        w_status = ST_HEADER;
        w_pay    = 8'd0;
        unique case (i_state.phase)
            PH_RIFF: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.phase = (w_tag_sh == SIG_RIFF) ? PH_RLEN : PH_BAD;
                end
            end
            PH_RLEN: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.phase = PH_WAVE;
                end
            end
            PH_WAVE: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.phase = (w_tag_sh == SIG_WAVE) ? PH_CID : PH_BAD;
                end
            end
            PH_CID: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.phase = PH_CLEN;
                end
            end
            PH_CLEN: begin
                // The chunk id stays in the tag register while the length shifts in.
                n_st.clen = w_clen_sh;
                n_st.idx  = w_idx4;
                if (w_done4) begin
                    if (i_state.tag == SIG_FMT) begin
                        if (w_clen_sh < FMT_MIN_LEN) begin
                            n_st.phase = PH_BAD;
                        end else begin
                            n_st.skip  = w_clen_sh - FMT_MIN_LEN;
                            n_st.phase = PH_FMT_CODE;
                        end
                    end else if (i_state.tag == SIG_DATA) begin
                        n_st.phase = PH_DATA;
                    end else begin
                        n_st.skip  = w_clen_sh;
                        n_st.phase = (w_clen_sh != 32'd0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_FMT_CODE: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx2;
                if (w_done2) begin
                    n_st.fmt   = w_tag_sh[31:16];
                    n_st.phase = PH_FMT_CH;
                end
            end
            PH_FMT_CH: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx2;
                if (w_done2) begin
                    n_st.chan  = w_tag_sh[31:16];
                    n_st.phase = PH_FMT_RATE;
                end
            end
            PH_FMT_RATE: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.rate  = w_tag_sh;
                    n_st.phase = PH_FMT_BRATE;
                end
            end
            PH_FMT_BRATE: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx4;
                if (w_done4) begin
                    n_st.phase = PH_FMT_ALIGN;
                end
            end
            PH_FMT_ALIGN: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx2;
                if (w_done2) begin
                    n_st.phase = PH_FMT_BITS;
                end
            end
            PH_FMT_BITS: begin
                n_st.tag = w_tag_sh;
                n_st.idx = w_idx2;
                if (w_done2) begin
                    n_st.bits = w_tag_sh[31:16];
                    if (i_state.fmt != FMT_PCM) begin
                        n_st.phase = PH_NOCODEC;
                    end else begin
                        n_st.phase = (i_state.skip != 32'd0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_SKIP: begin
                n_st.skip = w_skip_dec;
                if (w_skip_dec == 32'd0) begin
                    n_st.phase = PH_CID;
                end
            end
            PH_DATA: begin
                w_status = ST_PAYLOAD;
                w_pay    = i_byte;
            end
            PH_NOCODEC: begin
            end
            default: begin
                n_st.phase = PH_BAD;
            end
        endcase

        // A stream that ends before the data chunk is reached is invalid unless its coding is unsupported.
        if (i_eos && n_st.phase != PH_DATA && n_st.phase != PH_NOCODEC) begin
            n_st.phase = PH_BAD;
        end

        if (n_st.phase == PH_BAD) begin
            w_status = ST_INVALID;
            w_pay    = 8'd0;
        end else if (n_st.phase == PH_NOCODEC) begin
            w_status = ST_UNSUPPORTED;
            w_pay    = 8'd0;
        end
    end

    assign o_state   = n_st;
    assign o_status  = w_status;
    assign o_payload = w_pay;

endmodule

FILE: design/wav_header_parser.sv
// Top level of the RIFF/WAVE header parser with payload pass-through.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_stall   i_stream_byte, i_end_of_stream
//   out      output     o_out_valid / i_out_stall o_status, o_payload_byte,
//                                                 o_sample_rate, o_channel_count,
//                                                 o_sample_bits, o_stream_end
//
// One word is taken per cycle while the input is not stalled; each accepted word is captured
// in the input register, and when the output can advance, the parse step updates the parser
// state and loads the result register from it.
// Reset is synchronous and returns the parser to the RIFF tag check with all fields zero.
// While the output is stalled, the input register holds one more word before the
// input stalls.
module wav_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_channel_count,
    output logic [15:0] o_sample_bits,
    output logic        o_stream_end
);
    import wavh_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_eos;
    t_parse_state r_state;
    t_parse_state n_state;
    t_status      n_status;
    logic [7:0]   n_payload;
    logic         r_out_valid;
    t_status      r_status;
    logic [7:0]   r_payload;
    logic [31:0]  r_rate;
    logic [15:0]  r_chan;
    logic [15:0]  r_bits;
    logic         r_end;
    logic         w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    wavh_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_eos     (r_in_eos),
        .o_state   (n_state),
        .o_status  (n_status),
        .o_payload (n_payload)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PARSE_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_stream_byte;
            r_in_eos  <= i_end_of_stream;
        end
        if (w_advance) begin
            r_status  <= n_status;
            r_payload <= n_payload;
            r_rate    <= n_state.rate;
            r_chan    <= n_state.chan;
            r_bits    <= n_state.bits;
            r_end     <= r_in_eos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_payload_byte  = r_payload;
    assign o_sample_rate   = r_rate;
    assign o_channel_count = r_chan;
    assign o_sample_bits   = r_bits;
    assign o_stream_end    = r_end;

    a_pay_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_PAYLOAD) |-> (r_payload == 8'd0))
        else $error("payload byte nonzero outside payload status");

    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_BAD) |=> (r_state.phase == PH_BAD))
        else $error("invalid-stream error cleared without reset");

    a_data_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DATA) |=> (r_state.phase == PH_DATA))
        else $error("left payload phase");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_SKIP) |-> (r_state.skip != 32'd0))
        else $error("skip phase with nothing left to skip");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held word");

endmodule

FILE: tb/wav_header_parser_tb.sv
// Self-checking testbench for the RIFF/WAVE header parser with payload pass-through.
module wav_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavh_pkg::*;

    localparam int N_WORDS     = 850;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         drain;
    } t_stream_word;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [15:0] bits;
        logic        eos;
    } t_parse_result;

    typedef enum int {
        SC_BAD_RIFF, SC_BAD_WAVE, SC_SHORT_FMT, SC_NON_PCM, SC_EARLY_END, SC_PAYLOAD
    } t_stream_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'd0;
    logic        in_eos = 1'b0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_sample_rate;
    logic [15:0] o_channel_count;
    logic [15:0] o_sample_bits;
    logic        o_stream_end;

    t_stream_word  send_q[$];
    t_parse_result parsed_q[$];
    t_stream_case  stream_case;

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int n_total = 0;
    int n_status[4] = '{0, 0, 0, 0};
    int tx_gap = 0;
    int rx_wait = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // Parser state as the testbench sees it; reset happens once, so it starts at reset values.
    t_phase      hdr_phase = PH_RIFF;
    logic [1:0]  byte_pos = 2'd0;
    logic [31:0] shift_reg = 32'd0;
    logic [31:0] chunk_len = 32'd0;
    logic [31:0] skip_left = 32'd0;
    logic [15:0] fmt_code = 16'd0;
    logic [31:0] rate_hz = 32'd0;
    logic [15:0] chan_cnt = 16'd0;
    logic [15:0] bit_depth = 16'd0;

    wav_header_parser u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_stream_byte   (in_byte),
        .i_end_of_stream (in_eos),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_status        (o_status),
        .o_payload_byte  (o_payload_byte),
        .o_sample_rate   (o_sample_rate),
        .o_channel_count (o_channel_count),
        .o_sample_bits   (o_sample_bits),
        .o_stream_end    (o_stream_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shifts one byte into the little-endian field register; true once the field is complete.
    function automatic bit take_field_byte(logic [7:0] b, int nbytes);
        bit done;
        shift_reg = {b, shift_reg[31:8]};
        done = (int'(byte_pos) + 1 >= nbytes);
        byte_pos = done ? 2'd0 : byte_pos + 2'd1;
        return done;
    endfunction

    function automatic t_parse_result parse_byte(logic [7:0] b, logic eos);
        t_parse_result r;
        bit done;
        r.status = ST_HEADER;
        r.payload = 8'd0;
        case (hdr_phase)
            PH_RIFF: if (take_field_byte(b, 4))
                hdr_phase = (shift_reg == SIG_RIFF) ? PH_RLEN : PH_BAD;
            PH_RLEN: if (take_field_byte(b, 4))
                hdr_phase = PH_WAVE;
            PH_WAVE: if (take_field_byte(b, 4))
                hdr_phase = (shift_reg == SIG_WAVE) ? PH_CID : PH_BAD;
            PH_CID: if (take_field_byte(b, 4))
                hdr_phase = PH_CLEN;
            PH_CLEN: begin
                // The chunk id stays in shift_reg while the length builds up separately.
                chunk_len = {b, chunk_len[31:8]};
                done = (byte_pos == 2'd3);
                byte_pos = done ? 2'd0 : byte_pos + 2'd1;
                if (done) begin
                    if (shift_reg == SIG_FMT) begin
                        if (chunk_len < FMT_MIN_LEN) begin
                            hdr_phase = PH_BAD;
                        end else begin
                            skip_left = chunk_len - FMT_MIN_LEN;
                            hdr_phase = PH_FMT_CODE;
                        end
                    end else if (shift_reg == SIG_DATA) begin
                        hdr_phase = PH_DATA;
                    end else begin
                        skip_left = chunk_len;
                        hdr_phase = (skip_left != 0) ? PH_SKIP : PH_CID;
                    end
                end
            end
            PH_FMT_CODE: if (take_field_byte(b, 2)) begin
                fmt_code = shift_reg[31:16];
                hdr_phase = PH_FMT_CH;
            end
            PH_FMT_CH: if (take_field_byte(b, 2)) begin
                chan_cnt = shift_reg[31:16];
                hdr_phase = PH_FMT_RATE;
            end
            PH_FMT_RATE: if (take_field_byte(b, 4)) begin
                rate_hz = shift_reg;
                hdr_phase = PH_FMT_BRATE;
            end
            PH_FMT_BRATE: if (take_field_byte(b, 4))
                hdr_phase = PH_FMT_ALIGN;
            PH_FMT_ALIGN: if (take_field_byte(b, 2))
                hdr_phase = PH_FMT_BITS;
            PH_FMT_BITS: if (take_field_byte(b, 2)) begin
                bit_depth = shift_reg[31:16];
                if (fmt_code != FMT_PCM) begin
                    hdr_phase = PH_NOCODEC;
                end else begin
                    hdr_phase = (skip_left != 0) ? PH_SKIP : PH_CID;
                end
            end
            PH_SKIP: begin
                if (skip_left != 0) begin
                    skip_left = skip_left - 32'd1;
                end
                if (skip_left == 0) begin
                    hdr_phase = PH_CID;
                end
            end
            PH_DATA: begin
                r.status = ST_PAYLOAD;
                r.payload = b;
            end
            PH_NOCODEC: ;
            default: hdr_phase = PH_BAD;
        endcase
        // An end marker inside the header is fatal unless coding was already rejected.
        if (eos && hdr_phase != PH_DATA && hdr_phase != PH_NOCODEC) begin
            hdr_phase = PH_BAD;
        end
        if (hdr_phase == PH_BAD) begin
            r.status = ST_INVALID;
            r.payload = 8'd0;
        end else if (hdr_phase == PH_NOCODEC) begin
            r.status = ST_UNSUPPORTED;
            r.payload = 8'd0;
        end
        r.rate = rate_hz;
        r.chans = chan_cnt;
        r.bits = bit_depth;
        r.eos = eos;
        return r;
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    task automatic put_byte(logic [7:0] b);
        send_q.push_back('{b: b, eos: 1'b0, drain: 1'b0});
    endtask

    task automatic put_le(logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            put_byte(v[8*i +: 8]);
        end
    endtask

    task automatic put_fmt(int len, logic [15:0] code, logic [15:0] chans, logic [31:0] rate,
                           logic [15:0] bits);
        put_le(SIG_FMT, 4);
        put_le(32'(len), 4);
        put_le(32'(code), 2);
        put_le(32'(chans), 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(32'(bits), 2);
        for (int i = 16; i < len; i++) begin
            put_byte(8'($urandom));
        end
    endtask

    task automatic put_other_chunk(int len);
        logic [31:0] id;
        do begin
            id = $urandom;
        end while (id == SIG_FMT || id == SIG_DATA);
        put_le(id, 4);
        put_le(32'(len), 4);
        repeat (len) put_byte(8'($urandom));
    endtask

    // Sender: a word is offered after its drawn gap; a drain word waits for all results first.
    always @(posedge i_clk) begin : drive
        t_stream_word w;
        bit taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_byte <= 8'd0;
            in_eos <= 1'b0;
            n_sent <= 0;
        end else begin
            taken = in_valid && !o_in_stall;
            if (taken) begin
                parsed_q.push_back(parse_byte(in_byte, in_eos));
                n_sent <= n_sent + 1;
                tx_gap = draw_wait(tx_calm);
                if ($urandom_range(0, 63) == 0) begin
                    tx_calm = !tx_calm;
                end
            end
            if (!in_valid || taken) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (send_q.size() != 0 &&
                             !(send_q[0].drain && (taken || n_sent != n_checked))) begin
                    w = send_q.pop_front();
                    in_byte <= w.b;
                    in_eos <= w.eos;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_parse_result e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            n_checked <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_status[o_status]++;
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got status %0d payload %0h",
                             $time, o_status, o_payload_byte);
                    n_errors++;
                end else begin
                    e = parsed_q.pop_front();
                    n_checked <= n_checked + 1;
                    check_field("status", 32'(e.status), 32'(o_status));
                    check_field("payload_byte", 32'(e.payload), 32'(o_payload_byte));
                    check_field("sample_rate", e.rate, o_sample_rate);
                    check_field("channel_count", 32'(e.chans), 32'(o_channel_count));
                    check_field("sample_bits", 32'(e.bits), 32'(o_sample_bits));
                    check_field("stream_end", 32'(e.eos), 32'(o_stream_end));
                end
                rx_wait = draw_wait(rx_calm);
                if ($urandom_range(0, 63) == 0) begin
                    rx_calm = !rx_calm;
                end
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        int hdr_len;
        logic [15:0] bad_code;
        pick = $urandom_range(0, 9);
        stream_case = (pick < 5) ? t_stream_case'(pick) : SC_PAYLOAD;

        if (stream_case == SC_BAD_RIFF) begin
            put_le(SIG_RIFF ^ (32'd1 << $urandom_range(0, 31)), 4);
        end else begin
            put_le(SIG_RIFF, 4);
        end
        put_le($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 4);
        if (stream_case == SC_BAD_WAVE) begin
            put_le(SIG_WAVE ^ (32'd1 << $urandom_range(0, 31)), 4);
        end else begin
            put_le(SIG_WAVE, 4);
        end

        if (stream_case != SC_BAD_RIFF && stream_case != SC_BAD_WAVE) begin
            // Empty chunk, odd-length chunk, then two fmt chunks with extreme fields.
            put_other_chunk(0);
            put_other_chunk(3);
            put_fmt(18, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
            put_fmt(16, FMT_PCM, 16'h0, 32'h0, 16'h0);
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 2) == 0) begin
                    put_fmt(16 + $urandom_range(0, 5), FMT_PCM, 16'($urandom), $urandom,
                            16'($urandom));
                end else begin
                    put_other_chunk($urandom_range(0, 13));
                end
            end
            case (stream_case)
                SC_SHORT_FMT: begin
                    put_le(SIG_FMT, 4);
                    put_le($urandom_range(0, 15), 4);
                end
                SC_NON_PCM: begin
                    case ($urandom_range(0, 2))
                        0: bad_code = 16'h0;
                        1: bad_code = 16'hFFFF;
                        default: begin
                            do begin
                                bad_code = 16'($urandom);
                            end while (bad_code == FMT_PCM);
                        end
                    endcase
                    put_fmt(16, bad_code, 16'($urandom), $urandom, 16'($urandom));
                    // The end marker on the last fmt byte must still report unsupported coding.
                    if ($urandom_range(0, 1) == 1) begin
                        send_q[$].eos = 1'b1;
                    end
                end
                SC_EARLY_END: send_q[$urandom_range(0, send_q.size() - 1)].eos = 1'b1;
                default: begin
                    put_le(SIG_DATA, 4);
                    put_le($urandom, 4);
                end
            endcase
        end

        hdr_len = send_q.size();
        while (send_q.size() < N_WORDS) begin
            send_q.push_back('{b: 8'($urandom), eos: ($urandom_range(0, 15) == 0),
                               drain: 1'b0});
        end
        send_q[hdr_len].drain = 1'b1;
        send_q[$urandom_range(hdr_len + 1, N_WORDS - 1)].drain = 1'b1;
        n_total = send_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total) @(posedge i_clk);
        while (n_checked != n_sent) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (parsed_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, parsed_q.size());
            n_errors++;
        end
        $display("Stream case %s: %0d words sent, %0d results checked.",
                 stream_case.name(), n_total, n_checked);
        $display("Result status counts: header %0d, payload %0d, invalid %0d, unsupported %0d.",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
